// ===== src/spmq_pkg.sv =====
// ----------------------------------------------------------------------------
// spmq_pkg
// types and codes shared by the strict priority multiqueue blocks
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int MODE_W   = 2;
  localparam int LEVEL_W  = 3;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TAKE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEAL    = 2'd2;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [LEVEL_W-1:0]  priority_level;
    logic [HANDLE_W-1:0] task_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] out_handle;
    logic [LEVEL_W-1:0]  out_level;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // what the response stage needs to know about a request in flight
  typedef struct packed {
    logic                has_handle;
    logic [LEVEL_W-1:0]  level;
    logic [STATUS_W-1:0] status;
  } meta_t;

endpackage

// ===== src/spmq_ram.sv =====
// ----------------------------------------------------------------------------
// spmq_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module spmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/spmq_level_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmq_level_ctrl
// per-level head pointers and counts, level selection and store addressing
// ----------------------------------------------------------------------------
module spmq_level_ctrl #(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      accept,
  input  spmq_pkg::req_t                            req,
  output logic                                      ram_we,
  output logic                                      ram_re,
  output logic [$clog2(NUM_LEVELS*QUEUE_DEPTH)-1:0] ram_addr,
  output spmq_pkg::meta_t                           meta
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(NUM_LEVELS * QUEUE_DEPTH);

  logic [PTR_W-1:0] head [NUM_LEVELS];
  logic [CNT_W-1:0] count [NUM_LEVELS];

  logic [NUM_LEVELS-1:0] nonempty;
  logic [LVL_W-1:0]      first_lv;
  logic [LVL_W-1:0]      last_lv;
  logic                  any_queued;
  logic                  prio_ok;
  logic [LVL_W-1:0]      sel_lv;
  logic [PTR_W-1:0]      sel_head;
  logic [CNT_W-1:0]      sel_cnt;
  logic [CNT_W-1:0]      offset;
  logic [SUM_W-1:0]      sum;
  logic [PTR_W-1:0]      pos;
  logic [PTR_W-1:0]      head_inc;
  logic                  upd_cnt;
  logic                  cnt_up;
  logic                  upd_head;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = (count[i] != '0);
    end
  end

  // most urgent and least urgent non-empty levels
  always_comb begin
    first_lv = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        first_lv = LVL_W'(i);
      end
    end
  end

  always_comb begin
    last_lv = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i]) begin
        last_lv = LVL_W'(i);
      end
    end
  end

  assign any_queued = |nonempty;
  assign prio_ok    = (32'(req.priority_level) < NUM_LEVELS);

  always_comb begin
    case (req.mode)
      spmq_pkg::MODE_TAKE:  sel_lv = first_lv;
      spmq_pkg::MODE_STEAL: sel_lv = last_lv;
      default:              sel_lv = prio_ok ? LVL_W'(req.priority_level) : '0;
    endcase
  end

  assign sel_head = head[sel_lv];
  assign sel_cnt  = count[sel_lv];

  always_comb begin
    case (req.mode)
      spmq_pkg::MODE_SCHEDULE: offset = sel_cnt;
      spmq_pkg::MODE_STEAL:    offset = sel_cnt - CNT_W'(1);
      default:                 offset = '0;
    endcase
  end

  // head plus offset stays below twice the depth, so one subtract wraps it
  assign sum      = SUM_W'(sel_head) + SUM_W'(offset);
  assign pos      = (sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(sum - SUM_W'(QUEUE_DEPTH))
                                                 : PTR_W'(sum);
  assign head_inc = (sel_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + PTR_W'(1);
  assign ram_addr = ADDR_W'(ADDR_W'(sel_lv) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(pos);

  always_comb begin
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    upd_cnt         = 1'b0;
    cnt_up          = 1'b0;
    upd_head        = 1'b0;
    meta.has_handle = 1'b0;
    meta.level      = '0;
    meta.status     = spmq_pkg::ST_INVALID;
    case (req.mode)
      spmq_pkg::MODE_SCHEDULE: begin
        meta.level = req.priority_level;
        if (!prio_ok) begin
          meta.status = spmq_pkg::ST_INVALID;
        end else if (sel_cnt >= CNT_W'(QUEUE_DEPTH)) begin
          meta.status = spmq_pkg::ST_FULL;
        end else begin
          meta.status = spmq_pkg::ST_OK;
          ram_we      = accept;
          upd_cnt     = 1'b1;
          cnt_up      = 1'b1;
        end
      end
      spmq_pkg::MODE_TAKE, spmq_pkg::MODE_STEAL: begin
        if (any_queued) begin
          meta.status     = spmq_pkg::ST_OK;
          meta.level      = spmq_pkg::LEVEL_W'(sel_lv);
          meta.has_handle = 1'b1;
          ram_re          = accept;
          upd_cnt         = 1'b1;
          upd_head        = (req.mode == spmq_pkg::MODE_TAKE);
        end else begin
          meta.status = spmq_pkg::ST_EMPTY;
        end
      end
      default: begin
        meta.status = spmq_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else if (accept) begin
      if (upd_cnt) begin
        count[sel_lv] <= cnt_up ? sel_cnt + CNT_W'(1) : sel_cnt - CNT_W'(1);
      end
      if (upd_head) begin
        head[sel_lv] <= head_inc;
      end
    end
  end

endmodule

// ===== src/strict_priority_multiqueue_with_steal.sv =====
// ----------------------------------------------------------------------------
// strict_priority_multiqueue_with_steal
// Bounded deque of task handles per priority level, level 0 most urgent.
// Schedule appends at the tail of a level, take removes the head of the most
// urgent non-empty level, steal removes the tail of the least urgent one;
// every request gives one response. One request is taken every cycle while
// responses are being taken, and a response can be taken once its request has
// passed the read of the single-port handle memory and then the response
// register. A stalled response holds one request in the read stage and then
// holds off further requests. Level counts and head pointers sit in
// flip-flops cleared by reset, so the block takes requests right after
// reset; the handle memory needs no clearing.
// ----------------------------------------------------------------------------
module strict_priority_multiqueue_with_steal #(
  parameter int NUM_LEVELS  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  spmq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output spmq_pkg::rsp_t rsp
);

  localparam int DEPTH      = NUM_LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int STORE_BITS = (HANDLE_BITS < spmq_pkg::HANDLE_W) ? HANDLE_BITS
                                                                 : spmq_pkg::HANDLE_W;

  logic                  accept;
  logic                  advance;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [STORE_BITS-1:0] ram_rdata;
  spmq_pkg::meta_t       meta;
  logic                  s1_valid;
  spmq_pkg::meta_t       s1_meta;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;
  assign accept    = req_valid && req_ready;

  spmq_level_ctrl #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .ram_we   (ram_we),
    .ram_re   (ram_re),
    .ram_addr (ram_addr),
    .meta     (meta)
  );

  spmq_ram #(
    .WIDTH (STORE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (req.task_handle[STORE_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // read data holds until the next accepted request issues a new read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
    if (advance) begin
      rsp.out_handle <= s1_meta.has_handle ? spmq_pkg::HANDLE_W'(ram_rdata) : '0;
      rsp.out_level  <= s1_meta.level;
      rsp.status     <= s1_meta.status;
    end
  end

endmodule

// ===== src/spmq_checker.sv =====
// ----------------------------------------------------------------------------
// spmq_checker
// port level checks on the strict priority multiqueue
// ----------------------------------------------------------------------------
module spmq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input spmq_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input spmq_pkg::rsp_t rsp
);

  // a response that waits keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // a fresh response follows an accepted request that went straight through the read stage
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
    else $error("response without a request");

  // nothing queued reports no handle and level zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == spmq_pkg::ST_EMPTY |-> rsp.out_handle == '0 && rsp.out_level == '0)
    else $error("empty response carries data");

  // rejected requests never return a handle
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == spmq_pkg::ST_FULL || rsp.status == spmq_pkg::ST_INVALID)
    |-> rsp.out_handle == '0)
    else $error("rejected request returned a handle");

endmodule

bind strict_priority_multiqueue_with_steal spmq_checker u_spmq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strict priority multiqueue. A short table of
// directed requests runs first, followed by random request streams that fill
// and drain the levels. Every accepted request is run through a behavioral
// copy of the per-level deques, and each response is compared in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int                          NUM_LEVELS     = 8;
  localparam int                          QUEUE_DEPTH    = 16;
  localparam int                          HANDLE_BITS    = 16;
  localparam logic [spmq_pkg::MODE_W-1:0] MODE_UNUSED    = 2'd3;
  localparam int                          N_RANDOM       = 1700;
  localparam int                          STEADY_FROM    = 300;
  localparam int                          STEADY_TO      = 600;
  localparam int                          HOLD_AT        = 900;
  localparam int                          HOLD_LEN       = 300;
  localparam int                          PAUSE_AT       = 1200;
  localparam int                          WATCHDOG_LIMIT = 2000;

  typedef struct {
    spmq_pkg::req_t r;
    bit             fixed;
    spmq_pkg::rsp_t want;
  } dir_row_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  spmq_pkg::req_t req;
  logic           rsp_valid;
  logic           rsp_ready;
  spmq_pkg::rsp_t rsp;

  // behavioral copy of the deques
  logic [HANDLE_BITS-1:0] lvl_slots [NUM_LEVELS][QUEUE_DEPTH];
  int                     lvl_head  [NUM_LEVELS];
  int                     lvl_fill  [NUM_LEVELS];

  spmq_pkg::rsp_t due_rsps [$];
  dir_row_t       dir_rows [$];
  int             errors = 0;
  int             n_sent;
  int             quiet_cycles = 0;
  bit             steady;

  strict_priority_multiqueue_with_steal #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic spmq_pkg::rsp_t queue_op_result(spmq_pkg::req_t r);
    spmq_pkg::rsp_t o;
    int             lv;
    int             slot;
    bit             found;
    o     = '0;
    found = 1'b0;
    case (r.mode)
      spmq_pkg::MODE_SCHEDULE: begin
        lv          = int'(r.priority_level);
        o.out_level = r.priority_level;
        if (lv >= NUM_LEVELS) begin
          o.status = spmq_pkg::ST_INVALID;
        end else if (lvl_fill[lv] == QUEUE_DEPTH) begin
          o.status = spmq_pkg::ST_FULL;
        end else begin
          slot                = (lvl_head[lv] + lvl_fill[lv]) % QUEUE_DEPTH;
          lvl_slots[lv][slot] = r.task_handle;
          lvl_fill[lv]++;
          o.status = spmq_pkg::ST_OK;
        end
      end
      spmq_pkg::MODE_TAKE: begin
        o.status = spmq_pkg::ST_EMPTY;
        for (lv = 0; lv < NUM_LEVELS; lv++) begin
          if (!found && lvl_fill[lv] != 0) begin
            found        = 1'b1;
            o.out_handle = lvl_slots[lv][lvl_head[lv]];
            o.out_level  = spmq_pkg::LEVEL_W'(lv);
            o.status     = spmq_pkg::ST_OK;
            lvl_head[lv] = (lvl_head[lv] + 1) % QUEUE_DEPTH;
            lvl_fill[lv]--;
          end
        end
      end
      spmq_pkg::MODE_STEAL: begin
        o.status = spmq_pkg::ST_EMPTY;
        for (lv = NUM_LEVELS - 1; lv >= 0; lv--) begin
          if (!found && lvl_fill[lv] != 0) begin
            found        = 1'b1;
            slot         = (lvl_head[lv] + lvl_fill[lv] - 1) % QUEUE_DEPTH;
            o.out_handle = lvl_slots[lv][slot];
            o.out_level  = spmq_pkg::LEVEL_W'(lv);
            o.status     = spmq_pkg::ST_OK;
            lvl_fill[lv]--;
          end
        end
      end
      default: begin
        o.status = spmq_pkg::ST_INVALID;
      end
    endcase
    return o;
  endfunction

  function automatic void add_row(spmq_pkg::req_t r, bit fixed, spmq_pkg::rsp_t want);
    dir_row_t row;
    row.r     = r;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // drives one request and waits for it to be taken; optionally drains
  task automatic send_req(spmq_pkg::req_t r, bit fixed, spmq_pkg::rsp_t want,
                          bit drain_after);
    spmq_pkg::rsp_t pred;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = queue_op_result(r);
    due_rsps.push_back(fixed ? want : pred);
    n_sent++;
    if (drain_after) begin
      req_valid <= 1'b0;
      while (due_rsps.size() != 0) @(posedge clk);
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  initial begin : req_side
    spmq_pkg::req_t               r;
    int                           sched_pct;
    int                           pick;
    logic [spmq_pkg::LEVEL_W-1:0] focus_a;
    logic [spmq_pkg::LEVEL_W-1:0] focus_b;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    n_sent    = 0;
    steady    = 1'b0;
    sched_pct = 50;
    focus_a   = '0;
    focus_b   = '0;
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      lvl_head[lv] = 0;
      lvl_fill[lv] = 0;
    end

    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_TAKE, 3'd0, 16'h0000}, 1'b1,
            spmq_pkg::rsp_t'{16'h0000, 3'd0, spmq_pkg::ST_EMPTY});
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_STEAL, 3'd0, 16'h0000}, 1'b1,
            spmq_pkg::rsp_t'{16'h0000, 3'd0, spmq_pkg::ST_EMPTY});
    add_row(spmq_pkg::req_t'{MODE_UNUSED, 3'd7, 16'hFFFF}, 1'b1,
            spmq_pkg::rsp_t'{16'h0000, 3'd0, spmq_pkg::ST_INVALID});
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_SCHEDULE, 3'd0, 16'h0000}, 1'b1,
            spmq_pkg::rsp_t'{16'h0000, 3'd0, spmq_pkg::ST_OK});
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_SCHEDULE, 3'd7, 16'hFFFF}, 1'b1,
            spmq_pkg::rsp_t'{16'h0000, 3'd7, spmq_pkg::ST_OK});
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_TAKE, 3'd5, 16'h1234}, 1'b0, '0);
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_STEAL, 3'd2, 16'hABCD}, 1'b0, '0);
    // fill one level to the brim, then overflow it
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      add_row(spmq_pkg::req_t'{spmq_pkg::MODE_SCHEDULE, 3'd4, 16'(k * 16'h1111 ^ 16'h8421)},
              1'b0, '0);
    end
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_SCHEDULE, 3'd4, 16'h5A5A}, 1'b1,
            spmq_pkg::rsp_t'{16'h0000, 3'd4, spmq_pkg::ST_FULL});
    add_row(spmq_pkg::req_t'{spmq_pkg::MODE_TAKE, 3'd0, 16'h0000}, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send_req(dir_rows[k].r, dir_rows[k].fixed, dir_rows[k].want, 1'b0);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      // every hundred requests pick a new fill/drain mix and two hot levels
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       sched_pct = 70;
          1:       sched_pct = 25;
          default: sched_pct = 47;
        endcase
        focus_a = spmq_pkg::LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
        focus_b = spmq_pkg::LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
      end
      steady = (i >= STEADY_FROM && i < STEADY_TO);
      r.task_handle = 16'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(0, 99) < 70) begin
        r.priority_level = $urandom_range(0, 1) ? focus_a : focus_b;
      end else begin
        r.priority_level = spmq_pkg::LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        r.mode = MODE_UNUSED;
      end else if (pick < 3 + sched_pct) begin
        r.mode = spmq_pkg::MODE_SCHEDULE;
      end else if ($urandom_range(0, 1)) begin
        r.mode = spmq_pkg::MODE_TAKE;
      end else begin
        r.mode = spmq_pkg::MODE_STEAL;
      end
      send_req(r, 1'b0, '0, i == PAUSE_AT || i == N_RANDOM - 1);
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && due_rsps.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : rsp_side
    spmq_pkg::rsp_t want;
    int             hold_left;
    bit             held;
    hold_left = 0;
    held      = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (due_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp);
          errors++;
        end else begin
          want = due_rsps[0];
          due_rsps.delete(0);
          if (rsp.out_handle !== want.out_handle) begin
            $error("out_handle: expected %h, got %h", want.out_handle, rsp.out_handle);
            errors++;
          end
          if (rsp.out_level !== want.out_level) begin
            $error("out_level: expected %0d, got %0d", want.out_level, rsp.out_level);
            errors++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
        end
      end
      // one long back-pressure stretch so the block fills and stalls requests
      if (!held && n_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== strict_priority_multiqueue_with_steal.f =====
src/spmq_pkg.sv
src/spmq_ram.sv
src/spmq_level_ctrl.sv
src/strict_priority_multiqueue_with_steal.sv
src/spmq_checker.sv
bench/tb_top.sv
